/* design/cdq_pkg.sv */
// Package with the shared types and constants of the circular deque.
package cdq_pkg;

  localparam int WORD_W = 32;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR
  } cell_op_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_DRAIN
  } seq_state_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  value;
  } cell_ctrl_t;

endpackage

/* design/cdq_in_if.sv */
// Interface of the request channel of the circular deque.
interface cdq_in_if import cdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic signed [WORD_W-1:0]  push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

/* design/cdq_out_if.sv */
// Interface of the result channel of the circular deque.
interface cdq_out_if import cdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  pop_value;
  logic [STAT_W-1:0]         status;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input pop_value, input status, input occupancy,
                output ready);
endinterface

/* design/cdq_cell.sv */
// One storage cell of the deque chain, with its slice of the rear readout chain.
module cdq_cell import cdq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctrl_t                ctrl,
  input  logic signed [WORD_W-1:0]  prev_data,
  input  logic                      prev_valid,
  input  logic signed [WORD_W-1:0]  next_data,
  input  logic                      next_valid,
  input  logic signed [WORD_W-1:0]  next_tap,
  output logic signed [WORD_W-1:0]  data,
  output logic                      valid,
  output logic signed [WORD_W-1:0]  tap
);

  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic                     valid_r, valid_nxt;
  logic signed [WORD_W-1:0] tap_r, tap_nxt;
  logic                     last;

  assign last = valid_r && !next_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    tap_nxt   = last ? data_r : next_tap;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_PUSH_FRONT: begin
        data_nxt  = prev_data;
        valid_nxt = prev_valid;
      end
      OP_PUSH_REAR: begin
        if (prev_valid && !valid_r) begin
          data_nxt  = ctrl.value;
          valid_nxt = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        data_nxt  = next_data;
        valid_nxt = next_valid;
      end
      OP_POP_REAR: begin
        if (last) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;
  assign tap   = tap_r;

endmodule

/* design/circular_deque.sv */
// Top level of the circular deque: a chain of storage cells and its sequencer.
//
//   Channel  Direction  Payload
//   in_ch    input      action, push_value
//   out_ch   output     pop_value, status, occupancy
//
// Pushes, front pops and rejected actions are answered without leaving the idle state.
// A rear pop waits in the drain state while the rear word walks the readout chain
// one cell per cycle toward the front cell.
// A new request is taken once the previous result is transferred or in the same cycle.
// Reset clears the valid bits, the word count and the sequencer.
module circular_deque import cdq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cdq_in_if.sink      in_ch,
  cdq_out_if.source   out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [WORD_W-1:0] cell_data  [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic signed [WORD_W-1:0] cell_tap   [CAPACITY];

  cell_ctrl_t               ctrl;
  seq_state_t               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            wait_r, wait_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] pop_value_r, pop_value_nxt;
  status_t                  status_r, status_nxt;
  logic                     in_fire;
  logic                     full;
  logic                     empty;
  logic [CW+OCC_W-1:0]      count_ext;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_data;
    logic                     prev_valid;
    logic signed [WORD_W-1:0] next_data;
    logic                     next_valid;
    logic signed [WORD_W-1:0] next_tap;

    if (i == 0) begin : g_head
      assign prev_data  = in_ch.push_value;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_data  = '0;
      assign next_valid = 1'b0;
      assign next_tap   = '0;
    end else begin : g_link
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
      assign next_tap   = cell_tap[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_data  (prev_data),
      .prev_valid (prev_valid),
      .next_data  (next_data),
      .next_valid (next_valid),
      .next_tap   (next_tap),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .tap        (cell_tap[i])
    );
  end

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign in_ch.ready = (state_r == SEQ_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop_value_nxt = pop_value_r;
    status_nxt    = status_r;
    ctrl.op       = OP_HOLD;
    ctrl.value    = in_ch.push_value;
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          pop_value_nxt = '0;
          status_nxt    = ST_OK;
          case (action_t'(in_ch.action)) inside
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctrl.op   = (action_t'(in_ch.action) == ACT_PUSH_FRONT) ?
                            OP_PUSH_FRONT : OP_PUSH_REAR;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                ctrl.op       = OP_POP_FRONT;
                pop_value_nxt = cell_data[0];
                count_nxt     = count_r - CW'(1);
              end
            end
            default: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                wait_nxt      = count_r - CW'(1);
                state_nxt     = SEQ_DRAIN;
              end
            end
          endcase
        end
      end
      SEQ_DRAIN: begin
        if (wait_r == '0) begin
          ctrl.op       = OP_POP_REAR;
          pop_value_nxt = cell_tap[0];
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          count_nxt     = count_r - CW'(1);
          state_nxt     = SEQ_IDLE;
        end else begin
          wait_nxt = wait_r - CW'(1);
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_value_r <= pop_value_nxt;
    status_r    <= status_nxt;
  end

  assign count_ext        = {{OCC_W{1'b0}}, count_r};
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = pop_value_r;
  assign out_ch.status    = status_r;
  assign out_ch.occupancy = count_ext[OCC_W-1:0];

endmodule
